FILE: rtl/core/cmr_pkg.sv
// shared widths, constants and types of the compression mode recommender
`default_nettype none
package cmr_pkg;

	localparam int MAX_DIMS_DEF = 32;
	localparam int TOTAL_W      = 32;
	localparam int DIM_W        = 5;
	localparam int POINTS_W     = 16;
	localparam int RUNS_W       = 16;
	localparam int CBITS_W      = 7;
	localparam int VBYTES_W     = 4;
	localparam int MODE_W       = 2;
	localparam int AVG_W        = VBYTES_W + 3;

	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;

	localparam int DIV_STEPS = TOTAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [MODE_W-1:0] {
		MODE_DEFLATE = 2'd0,
		MODE_SIGBITS = 2'd1,
		MODE_RLE     = 2'd2
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_CMP  = 5'b10000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/cmr_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module cmr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/cmr_div.sv
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module cmr_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [cmr_pkg::TOTAL_W-1:0] dividend,
	input  wire logic [cmr_pkg::TOTAL_W-1:0] divisor,
	output logic                             done,
	output logic      [cmr_pkg::TOTAL_W-1:0] quotient
);
	import cmr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [TOTAL_W-1:0]   dvd_q;
	logic [TOTAL_W-1:0]   dvs_q;
	logic [TOTAL_W-1:0]   rem_q;
	logic [TOTAL_W:0]     shifted;
	logic [TOTAL_W+1:0]   diff;
	logic                 qbit;

	assign shifted = {rem_q, dvd_q[TOTAL_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign qbit    = ~diff[TOTAL_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			dvd_q <= {dvd_q[TOTAL_W-2:0], qbit};
			rem_q <= qbit ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

FILE: rtl/core/compression_mode_recommender.sv
// compression mode recommender: one word per patch dimension, one mode word out per input word
//
// input channel s_*: one word per dimension of a patch. first_of_patch (tuser bit 0) adds the
// patch's point count and one patch to the global totals; the run and common-bit counts add to
// the totals of dim_index, kept in a memory of MAX_DIMS entries.
// output channel m_*: exactly one word per input word, in order, carrying the dimension and the
// recommended mode (0 deflate, 1 significant bits, 2 run-length).
// one word is in flight at a time: after acceptance it passes the memory update, the 32-step
// serial division of the common-bit total by the patch count, the multiply and the compare
// before it reaches the result register, and the next word is taken only back in idle, so no
// new word is accepted before the last one is through.
// the next word is taken as soon as the previous result sits in the output register, even when
// the receiver stalls; if the result register is still full when a new result is ready, the
// block holds that result and takes no input until m_tready frees the register.
// reset clears the global totals and marks every memory entry unwritten so it reads as zero;
// no clearing pass is needed and input is taken from the first cycle after reset.
`default_nettype none
module compression_mode_recommender #(
	parameter int MAX_DIMS = cmr_pkg::MAX_DIMS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// dim_index[4:0], patch_points[20:5], run_count[36:21], common_bits[43:37],
	// value_bytes[47:44]
	input  wire logic [cmr_pkg::IN_DATA_W-1:0]  s_tdata,
	// first_of_patch[0], is_float[1]
	input  wire logic [cmr_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// out_dim[4:0], mode[6:5], zero[7]
	output logic      [cmr_pkg::OUT_DATA_W-1:0] m_tdata
);
	import cmr_pkg::*;

	localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// input field unpacking
	logic [DIM_W-1:0]    in_dim;
	logic [POINTS_W-1:0] in_points;
	logic [RUNS_W-1:0]   in_runs;
	logic [CBITS_W-1:0]  in_cbits;
	logic [VBYTES_W-1:0] in_vbytes;
	logic                in_first;
	logic                in_float;

	assign in_dim    = s_tdata[4:0];
	assign in_points = s_tdata[20:5];
	assign in_runs   = s_tdata[36:21];
	assign in_cbits  = s_tdata[43:37];
	assign in_vbytes = s_tdata[47:44];
	assign in_first  = s_tuser[0];
	assign in_float  = s_tuser[1];

	state_t state_q;
	logic   accept;
	logic   load_out;

	logic [TOTAL_W-1:0] point_total_q;
	logic [TOTAL_W-1:0] patch_total_q;
	logic [MAX_DIMS-1:0] valid_q;

	logic [AW+DIM_W-1:0] dim_ext;
	logic [AW-1:0]       in_addr;
	logic                in_range;

	logic [DIM_W-1:0]    dim_q;
	logic [AW-1:0]       addr_q;
	logic                range_q;
	logic                float_q;
	logic [RUNS_W-1:0]   runs_q;
	logic [CBITS_W-1:0]  cbits_q;
	logic [VBYTES_W-1:0] vbytes_q;

	logic [2*TOTAL_W-1:0] ram_rdata;
	logic [2*TOTAL_W-1:0] ram_wdata;
	logic [TOTAL_W-1:0]   old_runs;
	logic [TOTAL_W-1:0]   old_cbits;
	logic [TOTAL_W-1:0]   new_runs;
	logic [TOTAL_W-1:0]   new_cbits;
	logic                 ram_we;

	logic [TOTAL_W+VBYTES_W-1:0]   raw_q;
	logic [TOTAL_W+VBYTES_W:0]     rle_q;
	logic [TOTAL_W+VBYTES_W-1:0]   ts_q;
	logic [AVG_W-1:0]              uniq_q;
	logic [TOTAL_W+AVG_W-1:0]      pu_q;

	logic               div_start;
	logic               div_done;
	logic [TOTAL_W-1:0] div_quot;
	logic [AVG_W-1:0]   width_bits;
	logic [AVG_W-1:0]   avg_sat;

	logic [TOTAL_W+VBYTES_W+2:0] lhs;
	logic [TOTAL_W+VBYTES_W+4:0] rhs;
	logic [TOTAL_W+VBYTES_W+2:0] rle_x4;
	mode_t                       mode_next;

	logic                out_valid_q;
	logic [DIM_W-1:0]    out_dim_q;
	mode_t               out_mode_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == ST_CMP) && (!out_valid_q || m_tready);

	assign dim_ext  = (AW+DIM_W)'(in_dim);
	assign in_addr  = dim_ext[AW-1:0];
	assign in_range = {{(TOTAL_W-DIM_W){1'b0}}, in_dim} < TOTAL_W'(MAX_DIMS);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_total_q <= '0;
			patch_total_q <= '0;
			valid_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
						if (in_first) begin
							point_total_q <= point_total_q + TOTAL_W'(in_points);
							patch_total_q <= patch_total_q + TOTAL_W'(1);
						end
					end
				end
				ST_UPD: begin
					state_q <= ST_DIV;
					if (range_q) begin
						valid_q[addr_q] <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word capture
	always_ff @(posedge clk) begin
		if (accept) begin
			dim_q    <= in_dim;
			addr_q   <= in_addr;
			range_q  <= in_range;
			float_q  <= in_float;
			runs_q   <= in_runs;
			cbits_q  <= in_cbits;
			vbytes_q <= in_vbytes;
		end
	end

	// read-modify-write of the per-dimension totals
	assign old_runs  = (range_q && valid_q[addr_q]) ? ram_rdata[TOTAL_W-1:0] : '0;
	assign old_cbits = (range_q && valid_q[addr_q]) ? ram_rdata[2*TOTAL_W-1:TOTAL_W] : '0;
	assign new_runs  = old_runs + TOTAL_W'(runs_q);
	assign new_cbits = old_cbits + TOTAL_W'(cbits_q);
	assign ram_wdata = {new_cbits, new_runs};
	assign ram_we    = (state_q == ST_UPD) && range_q;

	cmr_ram #(
		.WIDTH(2*TOTAL_W),
		.DEPTH(MAX_DIMS)
	) u_totals (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_q),
		.wdata(ram_wdata),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	assign div_start = (state_q == ST_UPD);

	cmr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(new_cbits),
		.divisor (patch_total_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// average common bits, saturated at the value width; no patches means zero
	assign width_bits = {vbytes_q, 3'b000};
	always_comb begin
		if (patch_total_q == '0) begin
			avg_sat = '0;
		end else if (div_quot > TOTAL_W'(width_bits)) begin
			avg_sat = width_bits;
		end else begin
			avg_sat = div_quot[AVG_W-1:0];
		end
	end

	// product stages
	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			raw_q <= (TOTAL_W+VBYTES_W)'(point_total_q) * (TOTAL_W+VBYTES_W)'(vbytes_q);
			rle_q <= (TOTAL_W+VBYTES_W+1)'(new_runs)
				* (TOTAL_W+VBYTES_W+1)'({1'b0, vbytes_q} + (VBYTES_W+1)'(1));
			ts_q  <= (TOTAL_W+VBYTES_W)'(patch_total_q) * (TOTAL_W+VBYTES_W)'(vbytes_q);
		end
		if (state_q == ST_DIV && div_done) begin
			uniq_q <= width_bits - avg_sat;
		end
		if (state_q == ST_MUL) begin
			pu_q <= (TOTAL_W+AVG_W)'(point_total_q) * (TOTAL_W+AVG_W)'(uniq_q);
		end
	end

	// sigbits test: 5*raw > 16*T*S + P*uniq ; rle test: raw > 4*rle
	assign lhs    = (TOTAL_W+VBYTES_W+3)'({raw_q, 2'b00}) + (TOTAL_W+VBYTES_W+3)'(raw_q);
	assign rhs    = (TOTAL_W+VBYTES_W+5)'({ts_q, 4'b0000}) + (TOTAL_W+VBYTES_W+5)'(pu_q);
	assign rle_x4 = {rle_q, 2'b00};

	always_comb begin
		mode_next = MODE_DEFLATE;
		if (range_q && !float_q) begin
			if ((TOTAL_W+VBYTES_W+3)'(raw_q) > rle_x4) begin
				mode_next = MODE_RLE;
			end else if ((TOTAL_W+VBYTES_W+5)'(lhs) > rhs) begin
				mode_next = MODE_SIGBITS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_dim_q  <= dim_q;
			out_mode_q <= mode_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_mode_q, out_dim_q};

endmodule
`default_nettype wire
